@@ design/coin_credit_accumulator_defines.svh @@
// Assertion macros of the coin credit accumulator, used by the controller.
`ifndef COIN_CREDIT_ACCUMULATOR_DEFINES_SVH
`define COIN_CREDIT_ACCUMULATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Concurrent assertion on an explicit clock and active-low reset.
`define CCA_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define CCA_ASSERT(lbl, prop, msg) \
  `CCA_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`else

`define CCA_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define CCA_ASSERT(lbl, prop, msg)

`endif

`endif

@@ design/cca_pkg.sv @@
// Types, constants and command/status structs of the coin credit accumulator.
`timescale 1ns / 1ps
`default_nettype none

package cca_pkg;

  // Number of coin slots carried in the slot value register
  localparam int NumSlots = 4;

  // Restoring divider: one quotient bit per step over a 9-bit dividend
  localparam int DivSteps = 9;
  localparam int DivCntW  = $clog2(DivSteps);

  // Stream payload widths
  localparam int InDataW  = 8;
  localparam int InUserW  = 2;
  localparam int OutDataW = 24;

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  // Register reset values
  localparam logic [7:0]  MaxCreditsRst     = 8'd10;
  localparam logic [7:0]  UnitsPerCreditRst = 8'd1;
  localparam logic [7:0]  UnitsPerBonusRst  = 8'd0;
  localparam logic [7:0]  BonusCreditsRst   = 8'd0;
  localparam logic        FreePlayRst       = 1'b0;
  localparam logic [31:0] SlotValuesRst     = 32'h0101_0101;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_COIN        = 2'd0,
    KIND_REMOVE      = 2'd1,
    KIND_CLEAR_ALL   = 2'd2,
    KIND_CLEAR_UNITS = 2'd3
  } kind_e;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_CREDIT_CAP   = 3'd0,
    REG_CREDIT_PRICE = 3'd1,
    REG_BONUS_SPAN   = 3'd2,
    REG_BONUS_AWARD  = 3'd3,
    REG_OPEN_PLAY    = 3'd4,
    REG_SLOT_VALUES  = 3'd5
  } reg_idx_e;

  // Divisor selection for the shared divider
  typedef enum logic {
    DIV_CREDIT = 1'b0,
    DIV_BONUS  = 1'b1
  } div_sel_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic     in_load;    // capture the input transaction
    logic     exec;       // apply the item kind, add coin units
    logic     div_start;  // load divider from the selected counter
    div_sel_e div_sel;
    logic     div_step;   // one restoring step
    logic     bonus_wb;   // bonus remainder back, product of blocks
    logic     bonus_add;  // saturating add of bonus credits
    logic     credit_wb;  // unit remainder back, capped credit add
    logic     out_load;   // load the output register
  } cca_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic coin_go;   // coin is counted
    logic bonus_en;  // bonus blocks are enabled
    logic div_last;  // divider is on its last step
  } cca_stat_t;

endpackage

`default_nettype wire

@@ design/cca_ctrl.sv @@
// Sequencing state machine of the coin credit accumulator.
`timescale 1ns / 1ps
`default_nettype none
`include "coin_credit_accumulator_defines.svh"

module cca_ctrl
  import cca_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire cca_stat_t stat_i,
  output cca_cmd_t       cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_LOAD   = 10'b00_0000_0010,
    S_BSTART = 10'b00_0000_0100,
    S_BDIV   = 10'b00_0000_1000,
    S_BMUL   = 10'b00_0001_0000,
    S_BADD   = 10'b00_0010_0000,
    S_CSTART = 10'b00_0100_0000,
    S_CDIV   = 10'b00_1000_0000,
    S_CFIN   = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.exec = 1'b1;
        if (!stat_i.coin_go) begin
          state_d = S_DONE;
        end else if (stat_i.bonus_en) begin
          state_d = S_BSTART;
        end else begin
          state_d = S_CSTART;
        end
      end
      S_BSTART: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_BONUS;
        state_d         = S_BDIV;
      end
      S_BDIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = S_BMUL;
        end
      end
      S_BMUL: begin
        cmd_o.bonus_wb = 1'b1;
        state_d        = S_BADD;
      end
      S_BADD: begin
        cmd_o.bonus_add = 1'b1;
        state_d         = S_CSTART;
      end
      S_CSTART: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_CREDIT;
        state_d         = S_CDIV;
      end
      S_CDIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = S_CFIN;
        end
      end
      S_CFIN: begin
        cmd_o.credit_wb = 1'b1;
        state_d         = S_DONE;
      end
      S_DONE: begin
        // Wait for the output register to be free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `CCA_ASSERT(a_accept_to_load, in_fire |=> (state_q == S_LOAD), "accepted item did not start")
  `CCA_ASSERT(a_no_overwrite, cmd_o.out_load |-> (!out_valid_q || out_ready_i), "result overwritten")
  `CCA_ASSERT(a_cdiv_to_fin, (state_q == S_CDIV && stat_i.div_last) |=> (state_q == S_CFIN), "credit division did not finish")
  `CCA_ASSERT(a_load_valid, cmd_o.out_load |=> out_valid_q, "loaded result not valid")

endmodule

`default_nettype wire

@@ design/cca_datapath.sv @@
// Counters, configuration registers, shared divider and output register.
`timescale 1ns / 1ps
`default_nettype none

module cca_datapath
  import cca_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic [InDataW-1:0]  in_data_i,
  input  wire logic [InUserW-1:0]  in_user_i,
  input  wire cca_cmd_t            cmd_i,
  output cca_stat_t                stat_o,
  output logic [OutDataW-1:0]      out_data_o
);

  // Configuration registers
  logic [7:0]  credit_cap_q;
  logic [7:0]  credit_price_q;
  logic [7:0]  bonus_span_q;
  logic [7:0]  bonus_award_q;
  logic        open_play_q;
  logic [31:0] slot_values_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_cap_q   <= MaxCreditsRst;
      credit_price_q <= UnitsPerCreditRst;
      bonus_span_q   <= UnitsPerBonusRst;
      bonus_award_q  <= BonusCreditsRst;
      open_play_q    <= FreePlayRst;
      slot_values_q  <= SlotValuesRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_CREDIT_CAP:   credit_cap_q   <= cfg_data_i[7:0];
        REG_CREDIT_PRICE: credit_price_q <= cfg_data_i[7:0];
        REG_BONUS_SPAN:   bonus_span_q   <= cfg_data_i[7:0];
        REG_BONUS_AWARD:  bonus_award_q  <= cfg_data_i[7:0];
        REG_OPEN_PLAY:    open_play_q    <= cfg_data_i[0];
        REG_SLOT_VALUES:  slot_values_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Accounting state
  logic [7:0]  credit_q;
  logic [8:0]  unit_q, bonus_q;
  logic [16:0] prod_q;
  logic [7:0]  paid_q;
  logic        partial_q, ignored_q;

  // Captured input transaction
  kind_e      kind_q;
  logic [1:0] slot_q;
  logic       tilt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      kind_q <= kind_e'(in_user_i[1:0]);
      slot_q <= in_data_i[1:0];
      tilt_q <= in_data_i[2];
    end
  end

  // Coin decode
  logic       slot_ok, at_cap, coin_go, coin_ign;
  logic [7:0] slot_units;

  assign slot_ok    = (int'(slot_q) < NumSlots);
  assign at_cap     = (credit_q >= credit_cap_q);
  assign coin_go    = (kind_q == KIND_COIN) && slot_ok && !tilt_q && !at_cap;
  assign coin_ign   = (kind_q == KIND_COIN) && slot_ok && (tilt_q || at_cap);
  assign slot_units = slot_values_q[{slot_q, 3'b000} +: 8];

  // Shared restoring divider, one quotient bit per step
  logic [7:0]         div_q, rem_q;
  logic [8:0]         quo_q, trial;
  logic [DivCntW-1:0] cnt_q;
  logic               ge;
  logic [8:0]         diff;

  assign trial = {rem_q, quo_q[8]};
  assign ge    = (trial >= {1'b0, div_q});
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= '0;
      cnt_q <= '0;
      if (cmd_i.div_sel == DIV_BONUS) begin
        div_q <= bonus_span_q;
        quo_q <= bonus_q;
      end else begin
        div_q <= (credit_price_q == 8'd0) ? 8'd1 : credit_price_q;
        quo_q <= unit_q;
      end
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? diff[7:0] : trial[7:0];
      quo_q <= {quo_q[7:0], ge};
      cnt_q <= cnt_q + DivCntW'(1);
    end
  end

  logic [17:0] bonus_sum;
  logic [7:0]  room, conv_add;

  assign bonus_sum = {10'd0, credit_q} + {1'b0, prod_q};
  assign room      = credit_cap_q - credit_q;
  assign conv_add  = (quo_q < {1'b0, room}) ? quo_q[7:0] : room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
      unit_q   <= '0;
      bonus_q  <= '0;
    end else begin
      if (cmd_i.exec) begin
        unique case (kind_q)
          KIND_COIN: begin
            if (coin_go) begin
              unit_q <= unit_q + {1'b0, slot_units};
              if (bonus_span_q != 8'd0) begin
                bonus_q <= bonus_q + {1'b0, slot_units};
              end
            end
          end
          KIND_REMOVE: begin
            if (credit_q != 8'd0) begin
              credit_q <= credit_q - 8'd1;
            end
          end
          KIND_CLEAR_ALL: begin
            credit_q <= '0;
            unit_q   <= '0;
            bonus_q  <= '0;
          end
          KIND_CLEAR_UNITS: begin
            unit_q  <= '0;
            bonus_q <= '0;
          end
          default: ;
        endcase
      end
      // Bonus remainder returns to its counter
      if (cmd_i.bonus_wb) begin
        bonus_q <= {1'b0, rem_q};
      end
      // Bonus credits ignore the cap but saturate at full scale
      if (cmd_i.bonus_add) begin
        credit_q <= (bonus_sum > 18'd255) ? 8'hFF : bonus_sum[7:0];
      end
      // Conversions add credits only up to the cap
      if (cmd_i.credit_wb) begin
        unit_q <= {1'b0, rem_q};
        if (!at_cap) begin
          credit_q <= credit_q + conv_add;
        end
      end
    end
  end

  // Product of bonus blocks and bonus credits, and coin flags
  always_ff @(posedge clk_i) begin
    if (cmd_i.bonus_wb) begin
      prod_q <= {8'd0, quo_q} * {9'd0, bonus_award_q};
    end
    if (cmd_i.exec) begin
      paid_q    <= '0;
      partial_q <= 1'b0;
      ignored_q <= coin_ign;
    end
    if (cmd_i.credit_wb) begin
      paid_q    <= quo_q[8] ? 8'hFF : quo_q[7:0];
      partial_q <= (quo_q == 9'd0);
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_o <= {5'd0, ignored_q, partial_q, paid_q,
                     (open_play_q || credit_q != 8'd0), credit_q};
    end
  end

  assign stat_o.coin_go  = coin_go;
  assign stat_o.bonus_en = (bonus_span_q != 8'd0);
  assign stat_o.div_last = (cnt_q == DivCntW'(DivSteps - 1));

endmodule

`default_nettype wire

@@ design/coin_credit_accumulator.sv @@
// Coin credit accumulator: item in, controller and datapath, one result out.
//
// Input stream: one event per transaction. tuser carries the kind (coin,
// remove credit, clear all, clear units); tdata carries the coin slot and
// the slam tilt flag. Output stream: one result per accepted item with the
// credit count, availability, conversions made and the coin flags.
// Configuration writes go through the cfg channel (always ready); the user must
// make them while no item is in flight, as the block itself does not enforce it.
// Path: a non-coin item or a dropped coin goes straight from the load state to
// the result; a counted coin runs a credit division, and when the bonus is
// enabled a bonus division first: each division runs 9 steps of a shared
// restoring divider, one quotient bit a cycle.
// One item is processed at a time; the input is ready again the cycle after
// the result is loaded.
// The output register holds a finished result while the receiver stalls,
// and the block still accepts and processes the next item; that item waits
// for the register to empty before it is delivered.
// Reset clears the credit and unit counters, loads the register defaults
// and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module coin_credit_accumulator
  import cca_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration write channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  // input stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // [1:0] coin_slot, [2] after_slam_tilt, [7:3] zero
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // [1:0] kind
  input  wire logic [InUserW-1:0]  s_axis_tuser,
  // output stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [7:0] credit_count, [8] credits_available, [16:9] paid_credits_added,
  // [17] partial_credit, [18] coin_ignored, [23:19] zero
  output logic [OutDataW-1:0]      m_axis_tdata
);

  cca_cmd_t  cmd;
  cca_stat_t stat;

  assign cfg_ready_o = 1'b1;

  cca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cca_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

@@ dv/tb_coin_credit_accumulator.sv @@
// Self-checking testbench of the coin credit accumulator with a credit scoreboard.
`timescale 1ns / 1ps

module tb_coin_credit_accumulator;
  import cca_pkg::*;

  localparam int DrainCycles = 30;
  localparam int NumPhases   = 17;
  localparam int PhaseItems  = 100;

  // Expected fields of one result transaction
  typedef struct {
    logic [7:0] credit_count;
    logic       credits_available;
    logic [7:0] paid_credits_added;
    logic       partial_credit;
    logic       coin_ignored;
  } credit_result_t;

  // Credit scoreboard: mirrors the register file and the counters, predicts results
  class credit_scoreboard;
    bit [7:0]       credit_cap;
    bit [7:0]       credit_price;
    bit [7:0]       bonus_span;
    bit [7:0]       bonus_award;
    bit             open_play;
    bit [31:0]      slot_values;
    bit [7:0]       credits;
    bit [8:0]       units;
    bit [8:0]       bonus_units;
    credit_result_t credit_results_q[$];
    int             errors;

    function new();
      credit_cap   = MaxCreditsRst;
      credit_price = UnitsPerCreditRst;
      bonus_span   = UnitsPerBonusRst;
      bonus_award  = BonusCreditsRst;
      open_play    = FreePlayRst;
      slot_values  = SlotValuesRst;
      credits      = '0;
      units        = '0;
      bonus_units  = '0;
      errors       = 0;
    endfunction

    function void set_reg(reg_idx_e idx, bit [31:0] value);
      case (idx)
        REG_CREDIT_CAP:   credit_cap   = value[7:0];
        REG_CREDIT_PRICE: credit_price = value[7:0];
        REG_BONUS_SPAN:   bonus_span   = value[7:0];
        REG_BONUS_AWARD:  bonus_award  = value[7:0];
        REG_OPEN_PLAY:    open_play    = value[0];
        REG_SLOT_VALUES:  slot_values  = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return credit_results_q.size();
    endfunction

    // Apply one accepted item to the mirrored counters and queue its result
    function void note_input(kind_e kind, bit [1:0] slot, bit tilt);
      credit_result_t r;
      int n, upc, blocks, total, conv, room;
      r.paid_credits_added = '0;
      r.partial_credit     = 1'b0;
      r.coin_ignored       = 1'b0;
      case (kind)
        KIND_COIN: begin
          if (int'(slot) >= NumSlots) begin
            // slot not fitted: dropped without flags
          end else if (tilt || credits >= credit_cap) begin
            r.coin_ignored = 1'b1;
          end else begin
            n     = int'(slot_values[8*slot +: 8]);
            upc   = (credit_price == 0) ? 1 : int'(credit_price);
            units = 9'(int'(units) + n);
            if (bonus_span != 0) begin
              bonus_units = 9'(int'(bonus_units) + n);
              blocks      = int'(bonus_units) / int'(bonus_span);
              bonus_units = 9'(int'(bonus_units) % int'(bonus_span));
              total       = int'(credits) + blocks * int'(bonus_award);
              credits     = (total > 255) ? 8'd255 : 8'(total);
            end
            conv  = int'(units) / upc;
            units = 9'(int'(units) % upc);
            if (conv > 0) begin
              // units past the cap are still consumed
              if (credits < credit_cap) begin
                room    = int'(credit_cap) - int'(credits);
                credits = 8'(int'(credits) + ((conv < room) ? conv : room));
              end
              r.paid_credits_added = (conv > 255) ? 8'd255 : 8'(conv);
            end else begin
              r.partial_credit = 1'b1;
            end
          end
        end
        KIND_REMOVE: begin
          if (credits != 0) credits = credits - 8'd1;
        end
        KIND_CLEAR_ALL: begin
          credits     = '0;
          units       = '0;
          bonus_units = '0;
        end
        default: begin
          units       = '0;
          bonus_units = '0;
        end
      endcase
      r.credit_count      = credits;
      r.credits_available = open_play || (credits != 0);
      credit_results_q.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("ERROR @%0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    endtask

    // Compare one output transaction with the oldest expectation
    task check_result(logic [OutDataW-1:0] data);
      credit_result_t r;
      if (credit_results_q.size() == 0) begin
        report("result with none pending", 32'(data), 32'd0);
      end else begin
        r = credit_results_q.pop_front();
        if (data[7:0] !== r.credit_count)
          report("credit_count", 32'(data[7:0]), 32'(r.credit_count));
        if (data[8] !== r.credits_available)
          report("credits_available", 32'(data[8]), 32'(r.credits_available));
        if (data[16:9] !== r.paid_credits_added)
          report("paid_credits_added", 32'(data[16:9]), 32'(r.paid_credits_added));
        if (data[17] !== r.partial_credit)
          report("partial_credit", 32'(data[17]), 32'(r.partial_credit));
        if (data[18] !== r.coin_ignored)
          report("coin_ignored", 32'(data[18]), 32'(r.coin_ignored));
      end
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [InUserW-1:0]  s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  credit_scoreboard sb;
  bit               idle_en;

  coin_credit_accumulator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Receiver: random stall bursts while idling is on
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (idle_en && $urandom_range(0, 4) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
    end
  end

  // Output monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // All tasks below start and end at a falling edge
  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.set_reg(idx, value);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_item(kind_e kind, logic [1:0] slot, logic tilt);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {5'b0, tilt, slot};
    s_axis_tuser  = kind;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    sb.note_input(kind, slot, tilt);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // Mostly coins, with enough removals and clears to keep leaving the cap
  task automatic send_random_item();
    kind_e kind;
    int    pick;
    pick = $urandom_range(0, 99);
    if (pick < 60)      kind = KIND_COIN;
    else if (pick < 85) kind = KIND_REMOVE;
    else if (pick < 93) kind = KIND_CLEAR_UNITS;
    else                kind = KIND_CLEAR_ALL;
    send_item(kind, 2'($urandom_range(0, 3)), ($urandom_range(0, 9) == 0));
  endtask

  // Wait until every expected result has come, then let the block settle
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // New setting of every register, extremes included
  task automatic load_random_settings();
    logic [7:0]  value;
    logic [31:0] slots;
    int          s;
    case ($urandom_range(0, 9))
      0:       value = 8'd0;
      1, 2:    value = 8'd255;
      default: value = 8'($urandom_range(1, 30));
    endcase
    write_reg(REG_CREDIT_CAP, 32'(value));
    case ($urandom_range(0, 9))
      0:       value = 8'd0;
      1:       value = 8'd255;
      2, 3:    value = 8'd1;
      default: value = 8'($urandom_range(1, 20));
    endcase
    write_reg(REG_CREDIT_PRICE, 32'(value));
    case ($urandom_range(0, 5))
      0, 1:    value = 8'd0;
      2:       value = 8'd255;
      default: value = 8'($urandom_range(1, 40));
    endcase
    write_reg(REG_BONUS_SPAN, 32'(value));
    case ($urandom_range(0, 5))
      0:       value = 8'd0;
      1:       value = 8'd255;
      default: value = 8'($urandom_range(0, 5));
    endcase
    write_reg(REG_BONUS_AWARD, 32'(value));
    write_reg(REG_OPEN_PLAY, 32'($urandom_range(0, 1)));
    for (s = 0; s < 4; s++) begin
      case ($urandom_range(0, 5))
        0:       slots[8*s +: 8] = 8'd0;
        1:       slots[8*s +: 8] = 8'd255;
        2:       slots[8*s +: 8] = 8'($urandom_range(0, 255));
        default: slots[8*s +: 8] = 8'($urandom_range(1, 20));
      endcase
    end
    write_reg(REG_SLOT_VALUES, slots);
  endtask

  // Main sequence
  initial begin : stimulus
    int p;
    sb            = new();
    idle_en       = 1'b1;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: coins, removal down to and at zero, slam tilt
    send_item(KIND_COIN, 2'd0, 1'b0);
    send_item(KIND_COIN, 2'd3, 1'b0);
    send_item(KIND_REMOVE, 2'd0, 1'b0);
    send_item(KIND_REMOVE, 2'd2, 1'b0);
    send_item(KIND_REMOVE, 2'd0, 1'b0);
    send_item(KIND_COIN, 2'd1, 1'b1);
    drain();

    // partial credits, bonus blocks, cap, credits always available
    write_reg(REG_CREDIT_CAP, 32'd5);
    write_reg(REG_CREDIT_PRICE, 32'd3);
    write_reg(REG_BONUS_SPAN, 32'd4);
    write_reg(REG_BONUS_AWARD, 32'd2);
    write_reg(REG_OPEN_PLAY, 32'd1);
    write_reg(REG_SLOT_VALUES, 32'hFF00_0201);
    send_item(KIND_COIN, 2'd0, 1'b0);
    send_item(KIND_COIN, 2'd1, 1'b0);
    send_item(KIND_COIN, 2'd2, 1'b0);
    send_item(KIND_CLEAR_UNITS, 2'd3, 1'b1);
    send_item(KIND_COIN, 2'd3, 1'b0);
    send_item(KIND_COIN, 2'd0, 1'b0);
    send_item(KIND_CLEAR_ALL, 2'd0, 1'b0);
    send_item(KIND_REMOVE, 2'd0, 1'b0);
    drain();

    // bonus overflow to 255, then a coin at the cap
    write_reg(REG_CREDIT_CAP, 32'd255);
    write_reg(REG_CREDIT_PRICE, 32'd0);
    write_reg(REG_BONUS_SPAN, 32'd1);
    write_reg(REG_BONUS_AWARD, 32'd255);
    write_reg(REG_OPEN_PLAY, 32'd0);
    write_reg(REG_SLOT_VALUES, 32'hFFFF_FFFF);
    send_item(KIND_COIN, 2'd3, 1'b0);
    send_item(KIND_COIN, 2'd2, 1'b0);
    send_item(KIND_CLEAR_ALL, 2'd1, 1'b0);
    drain();

    // zero units per credit acts as one: many conversions from one coin
    write_reg(REG_BONUS_SPAN, 32'd0);
    send_item(KIND_COIN, 2'd1, 1'b0);
    send_item(KIND_CLEAR_UNITS, 2'd0, 1'b0);
    drain();

    // zero cap: every coin dropped
    write_reg(REG_CREDIT_CAP, 32'd0);
    send_item(KIND_COIN, 2'd0, 1'b0);
    send_item(KIND_REMOVE, 2'd0, 1'b0);

    // random phases, idling off for the last ones
    for (p = 0; p < NumPhases; p++) begin
      drain();
      idle_en = (p >= NumPhases - 2) ? 1'b0 : ($urandom_range(0, 4) != 0);
      load_random_settings();
      repeat (PhaseItems) send_random_item();
    end

    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("coin_credit_accumulator verification clean");
    end else begin
      $display("coin_credit_accumulator verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("coin_credit_accumulator verification failed");
    $finish;
  end

endmodule
